// ===== hw/rtl/sei_cc_pkg.sv =====
// Shared types and constants for the SEI caption pair extractor.
// Depends on nothing.
`timescale 1ns / 1ps

package sei_cc_pkg;

  localparam int ChannelCount = 4;
  localparam int QueueDepth   = 4;

  localparam logic [1:0] KIND_PAIR    = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_MARKER  = 2'd2;

  typedef struct packed {
    logic [1:0] result_kind;
    logic       pair_type;
    logic [6:0] first_char;
    logic [6:0] second_char;
    logic       channel_known;
    logic [1:0] channel;
    logic       new_track;
    logic [1:0] track_index;
    logic       track_added;
    logic       last_of_unit;
  } result_t;

  // Request passed from the parser to the back end (up to two results).
  typedef struct packed {
    logic    has_a;
    result_t res_a;
    logic    has_b;
    result_t res_b;
  } req_t;

endpackage

// ===== hw/rtl/sei_cc_parse.sv =====
// Front end: byte parser of the SEI NAL unit and caption track assignment.
// Depends on sei_cc_pkg.
`timescale 1ns / 1ps

module sei_cc_parse #(
  parameter int CHANNEL_COUNT = sei_cc_pkg::ChannelCount
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_valid,
  input  logic [7:0]         data_byte,
  input  logic               first_byte,
  input  logic [15:0]        unit_length,
  output logic               req_valid,
  output sei_cc_pkg::req_t   req
);

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_TYPE  = 4'd1;
  localparam logic [3:0] PH_SIZE  = 4'd2;
  localparam logic [3:0] PH_SKIP  = 4'd3;
  localparam logic [3:0] PH_HDR   = 4'd4;
  localparam logic [3:0] PH_FLAGS = 4'd5;
  localparam logic [3:0] PH_EM    = 4'd6;
  localparam logic [3:0] PH_TRIP0 = 4'd7;
  localparam logic [3:0] PH_TRIP1 = 4'd8;
  localparam logic [3:0] PH_TRIP2 = 4'd9;
  localparam logic [3:0] PH_DRAIN = 4'd10;
  localparam int TW = $clog2(CHANNEL_COUNT + 1);

  logic [3:0]  phase_r, phase_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [15:0] kind_sum_r, kind_sum_nxt;
  logic [15:0] pay_left_r, pay_left_nxt;
  logic [63:0] hdr_r, hdr_nxt;
  logic [4:0]  pairs_r, pairs_nxt;
  logic [15:0] tbuf_r, tbuf_nxt;
  logic [CHANNEL_COUNT-1:0] map_set_r, map_set_nxt;
  logic [1:0]  map_trk_r [CHANNEL_COUNT];
  logic [1:0]  map_trk_nxt [CHANNEL_COUNT];
  logic [TW-1:0] found_r, found_nxt;
  logic        added_r, added_nxt;
  logic        req_valid_nxt;
  sei_cc_pkg::req_t req_nxt;

  logic [16:0] sum_k, sum_p;
  logic [15:0] len1, bl_dec, pl_dec;
  logic [7:0]  lead;
  logic [6:0]  d1, d2;
  logic [1:0]  ch;
  logic        emit;
  logic        has_b;
  sei_cc_pkg::result_t r0, r1;

  always_comb begin
    phase_nxt = phase_r;
    bytes_left_nxt = bytes_left_r;
    kind_sum_nxt = kind_sum_r;
    pay_left_nxt = pay_left_r;
    hdr_nxt = hdr_r;
    pairs_nxt = pairs_r;
    tbuf_nxt = tbuf_r;
    map_set_nxt = map_set_r;
    map_trk_nxt = map_trk_r;
    found_nxt = found_r;
    added_nxt = added_r;
    emit = 1'b0;
    r0 = '0;
    r1 = '0;
    has_b = 1'b0;
    len1 = (unit_length == 16'd0) ? 16'd1 : unit_length;
    bl_dec = bytes_left_r - 16'd1;
    pl_dec = pay_left_r - 16'd1;
    sum_k = {1'b0, kind_sum_r} + {9'd0, data_byte};
    sum_p = {1'b0, pay_left_r} + {9'd0, data_byte};
    lead = tbuf_r[15:8];
    d1 = tbuf_r[6:0];
    d2 = data_byte[6:0];
    ch = {lead[0], (d1 >= 7'h18)};
    if (byte_valid && first_byte) begin
      emit = 1'b1;
      bytes_left_nxt = len1 - 16'd1;
      added_nxt = 1'b0;
      kind_sum_nxt = '0;
      pay_left_nxt = '0;
      if (data_byte[4:0] == 5'd6) begin
        phase_nxt = (bytes_left_nxt >= 16'd2) ? PH_TYPE : PH_DRAIN;
      end else begin
        phase_nxt = PH_DRAIN;
      end
    end else if (byte_valid && phase_r != PH_IDLE && bytes_left_r != 16'd0) begin
      emit = 1'b1;
      bytes_left_nxt = bl_dec;
      case (phase_r)
        PH_TYPE: begin
          kind_sum_nxt = sum_k[16] ? 16'hFFFF : sum_k[15:0];
          if (data_byte != 8'hFF) phase_nxt = PH_SIZE;
        end
        PH_SIZE: begin
          pay_left_nxt = sum_p[16] ? 16'hFFFF : sum_p[15:0];
          if (data_byte != 8'hFF) begin
            if (pay_left_nxt > bl_dec) begin
              phase_nxt = PH_DRAIN;
            end else if (kind_sum_r == 16'd4 && pay_left_nxt > 16'd8) begin
              hdr_nxt = '0;
              tbuf_nxt = '0;
              phase_nxt = PH_HDR;
            end else if (pay_left_nxt == 16'd0) begin
              kind_sum_nxt = '0;
              phase_nxt = (bl_dec >= 16'd2) ? PH_TYPE : PH_DRAIN;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          pay_left_nxt = pl_dec;
          if (pl_dec == 16'd0) begin
            kind_sum_nxt = '0;
            phase_nxt = (bl_dec >= 16'd2) ? PH_TYPE : PH_DRAIN;
          end
        end
        PH_HDR: begin
          hdr_nxt = {hdr_r[55:0], data_byte};
          pay_left_nxt = pl_dec;
          tbuf_nxt = tbuf_r + 16'd1;
          if (tbuf_nxt >= 16'd8) begin
            tbuf_nxt = '0;
            if (hdr_nxt[63:56] == 8'hB5 && hdr_nxt[55:40] == 16'h0031 &&
                hdr_nxt[39:8] == 32'h47413934 && hdr_nxt[7:0] == 8'h03 &&
                pl_dec > 16'd2) begin
              phase_nxt = PH_FLAGS;
            end else if (pl_dec == 16'd0) begin
              kind_sum_nxt = '0;
              phase_nxt = (bl_dec >= 16'd2) ? PH_TYPE : PH_DRAIN;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_FLAGS: begin
          pay_left_nxt = pl_dec;
          tbuf_nxt = {15'd0, data_byte[6]};
          pairs_nxt = data_byte[4:0];
          phase_nxt = PH_EM;
        end
        PH_EM: begin
          pay_left_nxt = pl_dec;
          if (tbuf_r[0]) begin
            phase_nxt = (pairs_r == 5'd0 || pl_dec < 16'd3) ? PH_DRAIN : PH_TRIP0;
          end else if (pl_dec == 16'd0) begin
            kind_sum_nxt = '0;
            phase_nxt = (bl_dec >= 16'd2) ? PH_TYPE : PH_DRAIN;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_TRIP0: begin
          pay_left_nxt = pl_dec;
          tbuf_nxt = {8'd0, data_byte};
          if (data_byte[7:3] != 5'h1F) begin
            r0.result_kind = sei_cc_pkg::KIND_MARKER;
            has_b = 1'b1;
          end
          phase_nxt = PH_TRIP1;
        end
        PH_TRIP1: begin
          pay_left_nxt = pl_dec;
          tbuf_nxt = {tbuf_r[7:0], data_byte};
          phase_nxt = PH_TRIP2;
        end
        PH_TRIP2: begin
          pay_left_nxt = pl_dec;
          if (lead[2] && !lead[1] && !(d1 < 7'h10 && d2 < 7'h10)) begin
            has_b = 1'b1;
            r0.result_kind = sei_cc_pkg::KIND_PAIR;
            r0.pair_type = lead[0];
            r0.first_char = d1;
            r0.second_char = d2;
            if (d1[6:4] == 3'b001) begin
              r0.channel_known = 1'b1;
              r0.channel = ch;
              if (!map_set_r[ch]) begin
                map_set_nxt[ch] = 1'b1;
                map_trk_nxt[ch] = found_r[1:0];
                if (found_r < TW'(CHANNEL_COUNT)) found_nxt = found_r + TW'(1);
                added_nxt = 1'b1;
                r0.new_track = 1'b1;
                r0.track_index = found_r[1:0];
              end else begin
                r0.track_index = map_trk_r[ch];
              end
            end
          end
          pairs_nxt = pairs_r - 5'd1;
          phase_nxt = (pairs_nxt == 5'd0 || pl_dec < 16'd3) ? PH_DRAIN : PH_TRIP0;
        end
        default: begin
        end
      endcase
    end
    r1.result_kind = sei_cc_pkg::KIND_SUMMARY;
    r1.track_added = added_nxt;
    r1.last_of_unit = 1'b1;
    req_nxt = '0;
    req_valid_nxt = 1'b0;
    if (emit && bytes_left_nxt == 16'd0) begin
      phase_nxt = PH_IDLE;
      req_valid_nxt = 1'b1;
      if (has_b) begin
        req_nxt.has_a = 1'b1;
        req_nxt.res_a = r0;
        req_nxt.has_b = 1'b1;
        req_nxt.res_b = r1;
      end else begin
        req_nxt.has_a = 1'b1;
        req_nxt.res_a = r1;
      end
    end else if (emit && has_b) begin
      req_valid_nxt = 1'b1;
      req_nxt.has_a = 1'b1;
      req_nxt.res_a = r0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bytes_left_r <= '0;
      kind_sum_r <= '0;
      pay_left_r <= '0;
      hdr_r <= '0;
      pairs_r <= '0;
      tbuf_r <= '0;
      map_set_r <= '0;
      found_r <= '0;
      added_r <= 1'b0;
      req_valid <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      kind_sum_r <= kind_sum_nxt;
      pay_left_r <= pay_left_nxt;
      hdr_r <= hdr_nxt;
      pairs_r <= pairs_nxt;
      tbuf_r <= tbuf_nxt;
      map_set_r <= map_set_nxt;
      found_r <= found_nxt;
      added_r <= added_nxt;
      req_valid <= req_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    map_trk_r <= map_trk_nxt;
    req <= req_nxt;
  end

`ifndef SYNTHESIS
  a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
    found_r <= TW'(CHANNEL_COUNT)) else $error("track count overflow");
  a_map_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(map_set_r) == int'(found_r)) else $error("map and count disagree");
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> bytes_left_r == 16'd0) else $error("idle with bytes left");
`endif

endmodule

// ===== hw/rtl/sei_cc_queue.sv =====
// Request queue between parser and output, with flow-control credit.
// Depends on sei_cc_pkg.
`timescale 1ns / 1ps

module sei_cc_queue #(
  parameter int DEPTH = sei_cc_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  sei_cc_pkg::req_t wr_req,
  output logic             room,
  output logic             rd_valid,
  output sei_cc_pkg::req_t rd_req,
  input  logic             rd_en
);

  localparam int AW = $clog2(DEPTH);

  sei_cc_pkg::req_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  // Two slots reserved: the request in the parser register and the one the
  // byte accepted now may make.
  assign room = (int'(cnt_r) + 2) <= DEPTH;
  assign rd_valid = cnt_r != '0;
  assign rd_req = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_req;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + AW'(1);
      if (rd_en) rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> int'(cnt_r) < DEPTH) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> rd_valid) else $error("queue underflow");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= DEPTH) else $error("count out of range");
`endif

endmodule

// ===== hw/rtl/sei_cc_emit.sv =====
// Back end: splits a request into one or two results on the output channel.
// Depends on sei_cc_pkg.
`timescale 1ns / 1ps

module sei_cc_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  sei_cc_pkg::req_t    q_req,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output sei_cc_pkg::result_t out_res
);

  logic second_r;

  assign out_valid = q_valid;
  assign out_res = second_r ? q_req.res_b : q_req.res_a;
  assign q_pop = q_valid && out_ready && (second_r || !q_req.has_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r <= 1'b0;
    end else if (q_valid && out_ready) begin
      second_r <= !second_r && q_req.has_b;
    end
  end

`ifndef SYNTHESIS
  a_second_needs_b: assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> q_valid && q_req.has_b) else $error("second half without request");
  a_pop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !second_r) else $error("phase not cleared");
  a_has_a: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> q_req.has_a) else $error("empty request queued");
`endif

endmodule

// ===== hw/rtl/sei_caption_pair_extractor.sv =====
// Results pass through the parser request register and then the request queue.
// Throughput: one byte per cycle while in_ready is high; a byte yielding two results
// puts them on the output one after the other, absorbed by a 4-entry request queue
// (in_ready drops while fewer than two entries are free).
// Reset: synchronous active-low rst_n; parse idle, track map cleared, queue empty.
// Top level; uses sei_cc_pkg, sei_cc_parse, sei_cc_queue, sei_cc_emit.
`timescale 1ns / 1ps

module sei_caption_pair_extractor #(
  parameter int CHANNEL_COUNT = sei_cc_pkg::ChannelCount,
  parameter int QUEUE_DEPTH   = sei_cc_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic [15:0] in_unit_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic        out_pair_type,
  output logic [6:0]  out_first_char,
  output logic [6:0]  out_second_char,
  output logic        out_channel_known,
  output logic [1:0]  out_channel,
  output logic        out_new_track,
  output logic [1:0]  out_track_index,
  output logic        out_track_added,
  output logic        out_last_of_unit
);

  logic room, pv, qv, pop;
  sei_cc_pkg::req_t preq, qreq;
  sei_cc_pkg::result_t res;

  // room already counts the request that may sit in the parser register
  assign in_ready = room;

  sei_cc_parse #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_parse (
    .clk(clk), .rst_n(rst_n), .byte_valid(in_valid && in_ready),
    .data_byte(in_data_byte), .first_byte(in_first_byte),
    .unit_length(in_unit_length), .req_valid(pv), .req(preq)
  );

  sei_cc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .wr_en(pv), .wr_req(preq), .room(room),
    .rd_valid(qv), .rd_req(qreq), .rd_en(pop)
  );

  sei_cc_emit u_emit (
    .clk(clk), .rst_n(rst_n), .q_valid(qv), .q_req(qreq), .q_pop(pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_res(res)
  );

  assign out_result_kind   = res.result_kind;
  assign out_pair_type     = res.pair_type;
  assign out_first_char    = res.first_char;
  assign out_second_char   = res.second_char;
  assign out_channel_known = res.channel_known;
  assign out_channel       = res.channel;
  assign out_new_track     = res.new_track;
  assign out_track_index   = res.track_index;
  assign out_track_added   = res.track_added;
  assign out_last_of_unit  = res.last_of_unit;

endmodule
